// File: rtl/tlpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants of the traffic light phase controller
// Phase and command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tlpc_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [2:0] {
        PH_GREEN    = 3'd0,
        PH_YELLOW   = 3'd1,
        PH_RED      = 3'd2,
        PH_BLINK    = 3'd3,
        PH_DISABLED = 3'd4,
        PH_ERROR    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        FN_TICK        = 3'd0,
        FN_ENABLE      = 3'd1,
        FN_DISABLE     = 3'd2,
        FN_START_BLINK = 3'd3,
        FN_STOP_BLINK  = 3'd4,
        FN_FORCE_GREEN = 3'd5,
        FN_STEP_RED    = 3'd6
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GREEN_TIME     = 3'd0,
        REG_YELLOW_TIME    = 3'd1,
        REG_RED_TIME       = 3'd2,
        REG_MIN_GREEN_TIME = 3'd3,
        REG_BLINK_PERIOD   = 3'd4,
        REG_BUTTON_PRESENT = 3'd5,
        REG_LAMPS_READY    = 3'd6
    } t_reg_idx;

    localparam logic [CFG_W-1:0] GREEN_TIME_RST     = 24'd10000;
    localparam logic [CFG_W-1:0] YELLOW_TIME_RST    = 24'd3000;
    localparam logic [CFG_W-1:0] RED_TIME_RST       = 24'd10000;
    localparam logic [CFG_W-1:0] MIN_GREEN_TIME_RST = 24'd5000;
    localparam logic [CFG_W-1:0] BLINK_PERIOD_RST   = 24'd500;

endpackage

// File: rtl/traffic_light_phase_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_top: traffic light phase sequencer
// Items on the input channel are millisecond ticks (with the sampled
// pedestrian button level) or commands. Each accepted item yields one
// result: phase, lamp drives, status LED, phase-entry flag, prior phase.
// User writes timing registers on the write port while idle; not enforced.
//
// Input channel i_in_valid/o_in_ready, result channel o_out_valid/i_out_ready.
// The phase state and the result register load at the edge that accepts
// the item, and the result shows on the next cycle.
// Throughput is one item per cycle, set by the single result register: an
// item is taken whenever that register is empty or is being read out in the
// same cycle. When the receiver stalls the result holds and o_in_ready drops
// until it is taken.
// Reset (synchronous, active low) loads the register defaults and enters the
// disabled phase with timer and blink state cleared.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller_top #(
    parameter int TIME_BITS = tlpc_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_func,
    input  logic                           i_button_pressed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_phase,
    output logic                           o_green_lamp,
    output logic                           o_yellow_lamp,
    output logic                           o_red_lamp,
    output logic                           o_status_led,
    output logic                           o_changed,
    output logic [2:0]                     o_prior_phase
);

    localparam int CMP_W = (TIME_BITS > tlpc_pkg::CFG_W) ? TIME_BITS : tlpc_pkg::CFG_W;

    logic [tlpc_pkg::CFG_W-1:0] r_green_time;
    logic [tlpc_pkg::CFG_W-1:0] r_yellow_time;
    logic [tlpc_pkg::CFG_W-1:0] r_red_time;
    logic [tlpc_pkg::CFG_W-1:0] r_min_green_time;
    logic [tlpc_pkg::CFG_W-1:0] r_blink_period;
    logic                       r_button_present;
    logic                       r_lamps_ready;

    tlpc_pkg::t_phase r_phase, n_phase;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic r_yellow_lit, n_yellow_lit;
    logic r_status_lit, n_status_lit;
    logic n_changed;

    logic r_out_valid;
    logic [2:0] r_out_phase;
    logic r_out_green, r_out_yellow, r_out_red, r_out_status, r_out_changed;
    logic [2:0] r_out_prior;

    logic [TIME_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0] elapsed_cmp;
    logic enter_req;
    tlpc_pkg::t_phase enter_tgt;
    logic accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_time     <= tlpc_pkg::GREEN_TIME_RST;
            r_yellow_time    <= tlpc_pkg::YELLOW_TIME_RST;
            r_red_time       <= tlpc_pkg::RED_TIME_RST;
            r_min_green_time <= tlpc_pkg::MIN_GREEN_TIME_RST;
            r_blink_period   <= tlpc_pkg::BLINK_PERIOD_RST;
            r_button_present <= 1'b1;
            r_lamps_ready    <= 1'b1;
        end else if (i_cfg_we) begin
            case (tlpc_pkg::t_reg_idx'(i_cfg_idx))
                tlpc_pkg::REG_GREEN_TIME:     r_green_time     <= i_cfg_data;
                tlpc_pkg::REG_YELLOW_TIME:    r_yellow_time    <= i_cfg_data;
                tlpc_pkg::REG_RED_TIME:       r_red_time       <= i_cfg_data;
                tlpc_pkg::REG_MIN_GREEN_TIME: r_min_green_time <= i_cfg_data;
                tlpc_pkg::REG_BLINK_PERIOD:   r_blink_period   <= i_cfg_data;
                tlpc_pkg::REG_BUTTON_PRESENT: r_button_present <= i_cfg_data[0];
                tlpc_pkg::REG_LAMPS_READY:    r_lamps_ready    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturating timer
    assign elapsed_inc = (r_elapsed == {TIME_BITS{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;
    assign elapsed_cmp = CMP_W'(elapsed_inc);

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_yellow_lit = r_yellow_lit;
        n_status_lit = r_status_lit;
        n_changed    = 1'b0;
        enter_req    = 1'b0;
        enter_tgt    = r_phase;

        if (tlpc_pkg::t_func'(i_func) == tlpc_pkg::FN_TICK) begin
            n_elapsed = elapsed_inc;
            case (r_phase)
                tlpc_pkg::PH_GREEN: begin
                    if ((r_button_present && i_button_pressed &&
                         elapsed_cmp >= CMP_W'(r_min_green_time)) ||
                        elapsed_cmp >= CMP_W'(r_green_time)) begin
                        enter_req = 1'b1;
                        enter_tgt = tlpc_pkg::PH_YELLOW;
                    end
                end
                tlpc_pkg::PH_YELLOW: begin
                    if (elapsed_cmp >= CMP_W'(r_yellow_time)) begin
                        enter_req = 1'b1;
                        enter_tgt = tlpc_pkg::PH_RED;
                    end
                end
                tlpc_pkg::PH_RED: begin
                    if (elapsed_cmp >= CMP_W'(r_red_time)) begin
                        enter_req = 1'b1;
                        enter_tgt = tlpc_pkg::PH_GREEN;
                    end
                end
                tlpc_pkg::PH_BLINK: begin
                    if (elapsed_cmp >= CMP_W'(r_blink_period)) begin
                        n_yellow_lit = !r_yellow_lit;
                        n_elapsed    = '0;
                    end
                end
                tlpc_pkg::PH_ERROR: begin
                    if (elapsed_cmp >= CMP_W'(r_blink_period)) begin
                        n_status_lit = !r_status_lit;
                        n_elapsed    = '0;
                    end
                end
                default: ;
            endcase
        end else if (!r_lamps_ready) begin
            if (r_phase != tlpc_pkg::PH_ERROR) begin
                n_phase   = tlpc_pkg::PH_ERROR;
                n_elapsed = '0;
            end
        end else if (r_phase != tlpc_pkg::PH_ERROR) begin
            case (tlpc_pkg::t_func'(i_func))
                tlpc_pkg::FN_ENABLE: begin
                    enter_req = (r_phase == tlpc_pkg::PH_DISABLED);
                    enter_tgt = tlpc_pkg::PH_GREEN;
                end
                tlpc_pkg::FN_DISABLE: begin
                    enter_req = (r_phase != tlpc_pkg::PH_DISABLED);
                    enter_tgt = tlpc_pkg::PH_DISABLED;
                end
                tlpc_pkg::FN_START_BLINK: begin
                    enter_req = (r_phase != tlpc_pkg::PH_BLINK);
                    enter_tgt = tlpc_pkg::PH_BLINK;
                end
                tlpc_pkg::FN_STOP_BLINK: begin
                    enter_req = (r_phase == tlpc_pkg::PH_BLINK);
                    enter_tgt = tlpc_pkg::PH_GREEN;
                end
                tlpc_pkg::FN_FORCE_GREEN: begin
                    enter_req = (r_phase == tlpc_pkg::PH_RED);
                    enter_tgt = tlpc_pkg::PH_GREEN;
                end
                tlpc_pkg::FN_STEP_RED: begin
                    enter_req = (r_phase == tlpc_pkg::PH_GREEN) ||
                                (r_phase == tlpc_pkg::PH_YELLOW);
                    enter_tgt = (r_phase == tlpc_pkg::PH_GREEN) ?
                                tlpc_pkg::PH_YELLOW : tlpc_pkg::PH_RED;
                end
                default: ;
            endcase
        end

        if (enter_req) begin
            n_elapsed = '0;
            if (!r_lamps_ready) begin
                n_phase = tlpc_pkg::PH_ERROR;
            end else begin
                n_phase      = enter_tgt;
                n_yellow_lit = (enter_tgt == tlpc_pkg::PH_YELLOW) ||
                               (enter_tgt == tlpc_pkg::PH_BLINK);
                n_changed    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tlpc_pkg::PH_DISABLED;
            r_elapsed    <= '0;
            r_yellow_lit <= 1'b0;
            r_status_lit <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_elapsed    <= n_elapsed;
                r_yellow_lit <= n_yellow_lit;
                r_status_lit <= n_status_lit;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_phase   <= n_phase;
            r_out_green   <= (n_phase == tlpc_pkg::PH_GREEN);
            r_out_yellow  <= (n_phase == tlpc_pkg::PH_YELLOW) ||
                             ((n_phase == tlpc_pkg::PH_BLINK) && n_yellow_lit);
            r_out_red     <= (n_phase == tlpc_pkg::PH_RED);
            r_out_status  <= n_status_lit;
            r_out_changed <= n_changed;
            r_out_prior   <= r_phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_phase       = r_out_phase;
    assign o_green_lamp  = r_out_green;
    assign o_yellow_lamp = r_out_yellow;
    assign o_red_lamp    = r_out_red;
    assign o_status_led  = r_out_status;
    assign o_changed     = r_out_changed;
    assign o_prior_phase = r_out_prior;

endmodule

// File: rtl/tlpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_checker: port-level checks of the traffic light phase controller
// Watches the result channel and flags lamp, phase and sequencing slips.
// ----------------------------------------------------------------------------
module tlpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_phase,
    input logic       o_green_lamp,
    input logic       o_yellow_lamp,
    input logic       o_red_lamp,
    input logic       o_changed,
    input logic [2:0] o_prior_phase
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_phase))
        else $error("stalled item changed");

    a_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_green_lamp, o_yellow_lamp, o_red_lamp}) <= 1)
        else $error("more than one lamp lit");

    a_error_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase == tlpc_pkg::PH_ERROR |->
            !o_changed && !o_green_lamp && !o_yellow_lamp && !o_red_lamp)
        else $error("error phase with lamp or change flag");

    a_change_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_changed |-> o_phase != o_prior_phase)
        else $error("change flag without phase change");

    a_prior_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) ##1 o_out_valid |-> o_prior_phase == $past(o_phase))
        else $error("prior phase does not follow last item");

endmodule

bind traffic_light_phase_controller_top tlpc_checker u_tlpc_checker (.*);
